// File: design/swsat_pkg.sv
package swsat_pkg;

	localparam int MAX_VERTS = 8;
	localparam int FRAC_BITS = 16;
	localparam int VAL_W     = 32;
	localparam int VERT_AW   = $clog2(MAX_VERTS);
	localparam int CNT_W     = $clog2(MAX_VERTS + 1);
	localparam int ACC_W     = 64;
	localparam int TIME_W    = 17;
	localparam int TFRAC_W   = 16;
	localparam int ENTRY_W   = 2 * VAL_W;

	localparam logic signed [ACC_W-1:0] FAR_BOUND = 64'sh1000_0000_0000_0000;
	localparam logic [TIME_W-1:0] NONE_TIME = '1;

	// opcodes
	localparam logic [2:0] OP_START   = 3'd0;
	localparam logic [2:0] OP_MV_VERT = 3'd1;
	localparam logic [2:0] OP_MV_NORM = 3'd2;
	localparam logic [2:0] OP_OB_VERT = 3'd3;
	localparam logic [2:0] OP_OB_NORM = 3'd4;
	localparam logic [2:0] OP_OB_END  = 3'd5;
	localparam logic [2:0] OP_FINISH  = 3'd6;

	// axis modes
	localparam logic [1:0] MODE_FULL = 2'd0;
	localparam logic [1:0] MODE_X    = 2'd1;

	// load count slots
	localparam int IDX_MV_V = 0;
	localparam int IDX_MV_N = 1;
	localparam int IDX_OB_V = 2;
	localparam int IDX_OB_N = 3;

	typedef enum logic [1:0] {
		SRC_MV,
		SRC_OV,
		SRC_VEL
	} src_t;

	typedef struct packed {
		logic valid;
		src_t src;
	} dot_tag_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NEXT,
		ST_AXIS_RD,
		ST_AXIS_LD,
		ST_WALK,
		ST_DRAIN,
		ST_SKIP_CHK,
		ST_EVAL1,
		ST_EVAL2,
		ST_DIV,
		ST_MERGE,
		ST_FINAL,
		ST_SCL_LO,
		ST_SCL_HI,
		ST_SCL_FIN,
		ST_CLEAR
	} state_t;

	function automatic logic signed [VAL_W-1:0] neg_sat(input logic signed [VAL_W-1:0] n);
		logic signed [VAL_W-1:0] r;
		if (n == {1'b1, {(VAL_W-1){1'b0}}})
			r = {1'b0, {(VAL_W-1){1'b1}}};
		else
			r = -n;
		return r;
	endfunction

endpackage

// File: design/swsat_ram.sv
module swsat_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// File: design/swsat_dot.sv
module swsat_dot import swsat_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dot_tag_t                tag_in,
	input  logic signed [VAL_W-1:0] ax,
	input  logic signed [VAL_W-1:0] ay,
	input  logic signed [VAL_W-1:0] bx,
	input  logic signed [VAL_W-1:0] by,
	output dot_tag_t                tag_out,
	output logic signed [ACC_W-1:0] dot
);
	dot_tag_t                  tag_s1, tag_s2;
	logic signed [2*VAL_W-1:0] px_s1, py_s1;
	logic signed [2*VAL_W:0]   sum_c, shr_c;
	logic signed [ACC_W-1:0]   dot_s2;

	// floor of the exact sum equals the sum of floors plus the carry of remainders
	assign sum_c = (2*VAL_W+1)'(px_s1) + (2*VAL_W+1)'(py_s1);
	assign shr_c = sum_c >>> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		px_s1  <= ax * bx;
		py_s1  <= ay * by;
		dot_s2 <= shr_c[ACC_W-1:0];
	end

	assign tag_out = tag_s2;
	assign dot     = dot_s2;
endmodule

// File: design/swsat_div.sv
module swsat_div import swsat_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [ACC_W-1:0]   num,
	input  logic [ACC_W-1:0]   den,
	output logic               done,
	output logic [TFRAC_W-1:0] quo
);
	logic [ACC_W-1:0]           rem_q, den_q;
	logic [TFRAC_W-1:0]         quo_q;
	logic [$clog2(TFRAC_W)-1:0] cnt_q;
	logic                       run_q, done_q;
	logic [ACC_W:0]             rem_sh;
	logic                       ge;

	// restoring division, one quotient bit per cycle; num < den
	assign rem_sh = {rem_q, 1'b0};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $clog2(TFRAC_W)'(TFRAC_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? ACC_W'(rem_sh - {1'b0, den_q}) : rem_sh[ACC_W-1:0];
			quo_q <= {quo_q[TFRAC_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

// File: design/swept_sat_polygon_list_collision.sv
// Loads, start and opcode seven complete on their accepting beat. Finish: result valid in the cycle after the beat.
// Obstacle end: each tested axis walks all Nm + No vertices and the velocity (Nm, No = loaded vertex counts),
//   plus a hit-time divide when the axis needs one; a two-vertex obstacle adds a skip check,
//   and a push result adds the push scaling. The worst case is set by the vertex walk
//   through the single dot product pipe and the bit-serial divider.
// Async reset: counts and flags clear, axis mask 3, velocity 0, hit time none; stores undefined.
module swept_sat_polygon_list_collision import swsat_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               opcode,
	input  logic signed [VAL_W-1:0]  x_value,
	input  logic signed [VAL_W-1:0]  y_value,
	input  logic [1:0]               axis_mode,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     is_overlapping,
	output logic                     will_hit,
	output logic [TIME_W-1:0]        hit_time,
	output logic signed [VAL_W-1:0]  hit_normal_x,
	output logic signed [VAL_W-1:0]  hit_normal_y,
	output logic signed [VAL_W-1:0]  push_x,
	output logic signed [VAL_W-1:0]  push_y,
	output logic signed [VAL_W-1:0]  move_x,
	output logic signed [VAL_W-1:0]  move_y,
	output logic [1:0]               axis_mask,
	output logic                     overflow
);
	state_t state_q, state_d;

	// frame level state
	logic [CNT_W-1:0]        cnt_q [4];
	logic signed [VAL_W-1:0] vel_x_q, vel_y_q;
	logic [1:0]              mask_q;
	logic                    over_f_q, will_f_q, ovf_q;
	logic [TIME_W-1:0]       earliest_q;
	logic signed [VAL_W-1:0] hn_x_q, hn_y_q, push_x_q, push_y_q;

	// per obstacle walk
	logic                    pass_q, skip_q;
	logic [CNT_W-1:0]        k_q;
	logic signed [VAL_W-1:0] ax_q, ay_q;
	src_t                    wsrc_q;
	logic [VERT_AW-1:0]      wi_q;
	dot_tag_t                iss_tag, tag_s0_q, dot_tag;
	logic signed [ACC_W-1:0] dot_val;
	logic signed [VAL_W-1:0] opb_x, opb_y;
	logic signed [ACC_W-1:0] p1n_q, p1x_q, p2n_q, p2x_q, va_q, dist_q;

	// axis outcome and running obstacle result
	logic                    is_i_q, will_i_q, ign_q;
	logic [TFRAC_W-1:0]      t_q;
	logic                    r_over_q, r_will_q, r_ign_q, r_own_q;
	logic signed [ACC_W-1:0] r_dist_q;
	logic [TFRAC_W-1:0]      r_t_q;
	logic signed [VAL_W-1:0] r_nx_q, r_ny_q;

	// push scaling
	logic                    sel_q;
	logic [2*VAL_W-1:0]      pa_q, pb_q;

	// output beat
	logic                    out_valid_q;

	logic                    acc;
	logic [1:0]              ld_idx;
	logic [3:0]              ld_we;
	logic                    ld_room;
	logic [ENTRY_W-1:0]      wdata;
	logic [ENTRY_W-1:0]      mv_v_rd, mv_n_rd, ob_v_rd, ob_n_rd;
	logic [1:0]              mask_new;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign acc      = in_valid && in_ready;
	assign wdata    = {y_value, x_value};

	// load decode: opcode 1..4 maps to store 0..3
	assign ld_idx  = 2'(opcode - OP_MV_VERT);
	assign ld_room = cnt_q[ld_idx] < CNT_W'(MAX_VERTS);
	always_comb begin
		ld_we = '0;
		if (acc && ld_room && (opcode == OP_MV_VERT || opcode == OP_MV_NORM ||
				opcode == OP_OB_VERT || opcode == OP_OB_NORM))
			ld_we[ld_idx] = 1'b1;
	end

	assign mask_new = (axis_mode == MODE_FULL) ? 2'b11 :
	                  (axis_mode == MODE_X) ? 2'b01 : 2'b10;

	swsat_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_VERTS)) u_mv_v (
		.clk(clk), .we(ld_we[IDX_MV_V]), .waddr(cnt_q[IDX_MV_V][VERT_AW-1:0]),
		.wdata(wdata), .raddr(wi_q), .rdata(mv_v_rd));
	swsat_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_VERTS)) u_mv_n (
		.clk(clk), .we(ld_we[IDX_MV_N]), .waddr(cnt_q[IDX_MV_N][VERT_AW-1:0]),
		.wdata(wdata), .raddr(k_q[VERT_AW-1:0]), .rdata(mv_n_rd));
	swsat_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_VERTS)) u_ob_v (
		.clk(clk), .we(ld_we[IDX_OB_V]), .waddr(cnt_q[IDX_OB_V][VERT_AW-1:0]),
		.wdata(wdata), .raddr(wi_q), .rdata(ob_v_rd));
	swsat_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_VERTS)) u_ob_n (
		.clk(clk), .we(ld_we[IDX_OB_N]), .waddr(cnt_q[IDX_OB_N][VERT_AW-1:0]),
		.wdata(wdata), .raddr(k_q[VERT_AW-1:0]), .rdata(ob_n_rd));

	// dot pipe operand: vertex from the store read last cycle, or the velocity
	always_comb begin
		unique case (tag_s0_q.src)
			SRC_MV: begin
				opb_x = mv_v_rd[VAL_W-1:0];
				opb_y = mv_v_rd[ENTRY_W-1:VAL_W];
			end
			SRC_OV: begin
				opb_x = ob_v_rd[VAL_W-1:0];
				opb_y = ob_v_rd[ENTRY_W-1:VAL_W];
			end
			default: begin
				opb_x = vel_x_q;
				opb_y = vel_y_q;
			end
		endcase
	end

	swsat_dot u_dot (
		.clk(clk), .arst_n(arst_n), .tag_in(tag_s0_q),
		.ax(ax_q), .ay(ay_q), .bx(opb_x), .by(opb_y),
		.tag_out(dot_tag), .dot(dot_val));

	// axis classification
	logic                    facing, reach, is_c, will_c, ign_c;
	logic signed [ACC_W-1:0] mag, d_a, d_b;
	logic                    div_done;
	logic [TFRAC_W-1:0]      div_q;

	assign d_a    = p2n_q - p1x_q;
	assign d_b    = p1n_q - p2x_q;
	assign mag    = va_q[ACC_W-1] ? -va_q : va_q;
	assign facing = pass_q ? (va_q > 0) : (va_q < 0);
	assign reach  = (va_q > 0 && p2n_q >= p1x_q) || (va_q < 0 && p1n_q >= p2x_q);

	always_comb begin
		is_c   = 1'b0;
		will_c = 1'b0;
		ign_c  = 1'b0;
		if (dist_q < 0)
			is_c = 1'b1;
		else if (reach) begin
			if (facing) begin
				ign_c = 1'b1;
				is_c  = 1'b1;
			end else if (dist_q < mag)
				will_c = 1'b1;
		end
	end

	swsat_div u_div (
		.clk(clk), .arst_n(arst_n),
		.start(state_q == ST_EVAL2 && will_c),
		.num(dist_q), .den(mag), .done(div_done), .quo(div_q));

	// merge of one axis into the obstacle result
	logic upd, n_over, n_will, n_ign, ret;
	assign upd = (!r_over_q && !r_will_q) ||
	             (r_over_q && (will_i_q || (is_i_q && !ign_q && (r_ign_q || r_dist_q < dist_q)))) ||
	             (r_will_q && will_i_q && t_q > r_t_q);
	always_comb begin
		n_over = r_over_q;
		n_will = r_will_q;
		n_ign  = r_ign_q;
		if (upd) begin
			n_over = is_i_q;
			n_will = will_i_q;
			n_ign  = ign_q;
		end else if (!is_i_q && !will_i_q) begin
			n_over = 1'b0;
			n_will = 1'b0;
		end
	end
	assign ret = !n_over && !n_will;

	// push = |normal| * |depth| >> FRAC_BITS, signed, saturated
	logic signed [VAL_W-1:0]  n_sel;
	logic [VAL_W-1:0]         un;
	logic [ACC_W-1:0]         ud;
	logic [3*VAL_W-1:0]       prod;
	logic [3*VAL_W-FRAC_BITS-1:0] mag_full, lim;
	logic                     neg;
	logic [VAL_W-1:0]         mag32;
	logic signed [VAL_W-1:0]  push_res;

	assign n_sel    = sel_q ? r_ny_q : r_nx_q;
	assign un       = n_sel[VAL_W-1] ? VAL_W'(-n_sel) : VAL_W'(n_sel);
	assign ud       = r_dist_q[ACC_W-1] ? ACC_W'(-r_dist_q) : ACC_W'(r_dist_q);
	assign prod     = {pb_q, {VAL_W{1'b0}}} + {{VAL_W{1'b0}}, pa_q};
	assign mag_full = prod[3*VAL_W-1:FRAC_BITS];
	assign neg      = n_sel[VAL_W-1] != !r_own_q;
	assign lim      = neg ? (3*VAL_W-FRAC_BITS)'({1'b1, {(VAL_W-1){1'b0}}})
	                      : (3*VAL_W-FRAC_BITS)'({1'b0, {(VAL_W-1){1'b1}}});
	assign mag32    = (mag_full > lim) ? lim[VAL_W-1:0] : mag_full[VAL_W-1:0];
	assign push_res = neg ? -$signed(mag32) : $signed(mag32);

	// walk issue
	always_comb begin
		iss_tag = '0;
		if (state_q == ST_WALK) begin
			iss_tag.valid = 1'b1;
			iss_tag.src   = wsrc_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && opcode == OP_OB_END) begin
					if (cnt_q[IDX_OB_V] == CNT_W'(2))
						state_d = (cnt_q[IDX_OB_N] == '0) ? ST_CLEAR : ST_AXIS_RD;
					else
						state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (pass_q && k_q == cnt_q[IDX_OB_N])
					state_d = ST_FINAL;
				else if (!(!pass_q && k_q == cnt_q[IDX_MV_N]))
					state_d = ST_AXIS_RD;
			end
			ST_AXIS_RD:  state_d = ST_AXIS_LD;
			ST_AXIS_LD:  state_d = ST_WALK;
			ST_WALK:     if (wsrc_q == SRC_VEL) state_d = ST_DRAIN;
			ST_DRAIN: begin
				if (dot_tag.valid && dot_tag.src == SRC_VEL)
					state_d = skip_q ? ST_SKIP_CHK : ST_EVAL1;
			end
			ST_SKIP_CHK: state_d = (va_q >= 0) ? ST_CLEAR : ST_NEXT;
			ST_EVAL1:    state_d = ST_EVAL2;
			ST_EVAL2:    state_d = will_c ? ST_DIV : ST_MERGE;
			ST_DIV:      if (div_done) state_d = ST_MERGE;
			ST_MERGE:    state_d = ret ? ST_CLEAR : ST_NEXT;
			ST_FINAL:    state_d = r_over_q ? ST_SCL_LO : ST_CLEAR;
			ST_SCL_LO:   state_d = ST_SCL_HI;
			ST_SCL_HI:   state_d = ST_SCL_FIN;
			ST_SCL_FIN:  state_d = sel_q ? ST_CLEAR : ST_SCL_LO;
			ST_CLEAR:    state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				cnt_q[i] <= '0;
			vel_x_q     <= '0;
			vel_y_q     <= '0;
			mask_q      <= 2'b11;
			over_f_q    <= 1'b0;
			will_f_q    <= 1'b0;
			ovf_q       <= 1'b0;
			earliest_q  <= NONE_TIME;
			pass_q      <= 1'b0;
			skip_q      <= 1'b0;
			k_q         <= '0;
			wsrc_q      <= SRC_MV;
			wi_q        <= '0;
			tag_s0_q    <= '0;
			r_over_q    <= 1'b0;
			r_will_q    <= 1'b0;
			r_ign_q     <= 1'b0;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			tag_s0_q <= iss_tag;
			// finish beat raises the result; it drops once taken
			if (acc && opcode == OP_FINISH)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (acc) begin
				unique case (opcode)
					OP_START: begin
						for (int i = 0; i < 4; i++)
							cnt_q[i] <= '0;
						mask_q     <= mask_new;
						vel_x_q    <= mask_new[0] ? x_value : '0;
						vel_y_q    <= mask_new[1] ? y_value : '0;
						over_f_q   <= 1'b0;
						will_f_q   <= 1'b0;
						ovf_q      <= 1'b0;
						earliest_q <= NONE_TIME;
					end
					OP_MV_VERT, OP_MV_NORM, OP_OB_VERT, OP_OB_NORM: begin
						if (ld_room)
							cnt_q[ld_idx] <= cnt_q[ld_idx] + 1'b1;
						else
							ovf_q <= 1'b1;
					end
					OP_OB_END: begin
						r_over_q <= 1'b0;
						r_will_q <= 1'b0;
						r_ign_q  <= 1'b0;
						k_q      <= '0;
						// two-vertex obstacle: check its first normal against the motion
						skip_q   <= cnt_q[IDX_OB_V] == CNT_W'(2);
						pass_q   <= cnt_q[IDX_OB_V] == CNT_W'(2);
					end
					default: ;
				endcase
			end

			unique case (state_q)
				ST_NEXT: begin
					if (!pass_q && k_q == cnt_q[IDX_MV_N]) begin
						pass_q <= 1'b1;
						k_q    <= '0;
					end
				end
				ST_AXIS_LD: begin
					wi_q <= '0;
					if (skip_q)
						wsrc_q <= SRC_VEL;
					else if (cnt_q[IDX_MV_V] != '0)
						wsrc_q <= SRC_MV;
					else if (cnt_q[IDX_OB_V] != '0)
						wsrc_q <= SRC_OV;
					else
						wsrc_q <= SRC_VEL;
				end
				ST_WALK: begin
					unique case (wsrc_q)
						SRC_MV: begin
							if (CNT_W'(wi_q) + CNT_W'(1) == cnt_q[IDX_MV_V]) begin
								wi_q   <= '0;
								wsrc_q <= (cnt_q[IDX_OB_V] != '0) ? SRC_OV : SRC_VEL;
							end else
								wi_q <= wi_q + 1'b1;
						end
						SRC_OV: begin
							if (CNT_W'(wi_q) + CNT_W'(1) == cnt_q[IDX_OB_V]) begin
								wi_q   <= '0;
								wsrc_q <= SRC_VEL;
							end else
								wi_q <= wi_q + 1'b1;
						end
						default: ;
					endcase
				end
				ST_SKIP_CHK: begin
					skip_q <= 1'b0;
					pass_q <= 1'b0;
					k_q    <= '0;
				end
				ST_MERGE: begin
					r_over_q <= n_over && !n_ign;
					r_will_q <= n_will;
					r_ign_q  <= n_ign;
					k_q      <= k_q + 1'b1;
				end
				ST_FINAL: begin
					sel_q <= 1'b0;
					if (!r_over_q && r_will_q && {1'b0, r_t_q} < earliest_q) begin
						earliest_q <= {1'b0, r_t_q};
						will_f_q   <= 1'b1;
					end
				end
				ST_SCL_FIN: begin
					sel_q <= 1'b1;
					if (sel_q)
						over_f_q <= 1'b1;
				end
				ST_CLEAR: begin
					cnt_q[IDX_OB_V] <= '0;
					cnt_q[IDX_OB_N] <= '0;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_AXIS_LD) begin
			ax_q  <= pass_q ? ob_n_rd[VAL_W-1:0] : mv_n_rd[VAL_W-1:0];
			ay_q  <= pass_q ? ob_n_rd[ENTRY_W-1:VAL_W] : mv_n_rd[ENTRY_W-1:VAL_W];
			// empty polygon projects far away
			p1n_q <= FAR_BOUND;
			p1x_q <= -FAR_BOUND;
			p2n_q <= FAR_BOUND;
			p2x_q <= -FAR_BOUND;
		end else if (dot_tag.valid) begin
			unique case (dot_tag.src)
				SRC_MV: begin
					if (dot_val < p1n_q) p1n_q <= dot_val;
					if (dot_val > p1x_q) p1x_q <= dot_val;
				end
				SRC_OV: begin
					if (dot_val < p2n_q) p2n_q <= dot_val;
					if (dot_val > p2x_q) p2x_q <= dot_val;
				end
				default: va_q <= dot_val;
			endcase
		end

		if (state_q == ST_EVAL1)
			dist_q <= (d_a > d_b) ? d_a : d_b;

		if (state_q == ST_EVAL2) begin
			is_i_q   <= is_c;
			will_i_q <= will_c;
			ign_q    <= ign_c;
			t_q      <= '0;
		end
		if (state_q == ST_DIV && div_done)
			t_q <= div_q;

		if (state_q == ST_MERGE && upd) begin
			r_dist_q <= dist_q;
			r_t_q    <= t_q;
			r_nx_q   <= ax_q;
			r_ny_q   <= ay_q;
			r_own_q  <= pass_q;
		end

		if (state_q == ST_FINAL && !r_over_q && r_will_q && {1'b0, r_t_q} < earliest_q) begin
			hn_x_q <= r_own_q ? r_nx_q : neg_sat(r_nx_q);
			hn_y_q <= r_own_q ? r_ny_q : neg_sat(r_ny_q);
		end

		if (state_q == ST_SCL_LO)
			pa_q <= un * ud[VAL_W-1:0];
		if (state_q == ST_SCL_HI)
			pb_q <= un * ud[ACC_W-1:VAL_W];
		if (state_q == ST_SCL_FIN) begin
			if (sel_q)
				push_y_q <= push_res;
			else
				push_x_q <= push_res;
		end

		// result beat snapshot; unused fields read as zero
		if (acc && opcode == OP_FINISH) begin
			is_overlapping <= over_f_q;
			will_hit       <= will_f_q;
			hit_time       <= will_f_q ? earliest_q : '0;
			hit_normal_x   <= will_f_q ? hn_x_q : '0;
			hit_normal_y   <= will_f_q ? hn_y_q : '0;
			push_x         <= over_f_q ? push_x_q : '0;
			push_y         <= over_f_q ? push_y_q : '0;
			move_x         <= vel_x_q;
			move_y         <= vel_y_q;
			axis_mask      <= mask_q;
			overflow       <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
endmodule

// File: design/swsat_chk.sv
module swsat_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic              is_overlapping,
	input logic              will_hit,
	input logic [16:0]       hit_time,
	input logic signed [31:0] hit_normal_x,
	input logic signed [31:0] hit_normal_y,
	input logic signed [31:0] push_x,
	input logic signed [31:0] push_y,
	input logic signed [31:0] move_y,
	input logic [1:0]        axis_mask
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit_time) && $stable(push_x))
		else $error("result beat changed while stalled");

	a_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_overlapping |-> push_x == 0 && push_y == 0)
		else $error("push without overlap");

	a_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !will_hit |-> hit_time == 0 && hit_normal_x == 0 && hit_normal_y == 0)
		else $error("hit fields without hit");

	a_hit_frac: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && will_hit |-> !hit_time[16])
		else $error("hit time not below one frame");

	a_mask_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && axis_mask == 2'b01 |-> move_y == 0)
		else $error("untested axis carries motion");
endmodule

bind swept_sat_polygon_list_collision swsat_chk u_swsat_chk (.*);
